FILE: src/mwm_pkg.sv
`timescale 1ns / 1ps
// mwm_pkg: shared types and codes for the maze wall map unit
// transaction structs, opcodes, side codes and wall masks; no dependencies

package mwm_pkg;

  // request and result transactions
  typedef struct packed {
    logic [2:0] opcode;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic [1:0] direction;
  } in_item_t;

  typedef struct packed {
    logic       wall_present;
    logic [3:0] cell_walls;
    logic       bad_request;
  } out_item_t;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 7;

  localparam logic [CfgIdxW-1:0] CFG_MAZE_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAZE_HEIGHT = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GOAL_X      = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_GOAL_Y      = 2'd3;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_BOUND = 3'd1;
  localparam logic [2:0] OP_MARK  = 3'd2;
  localparam logic [2:0] OP_CHECK = 3'd3;
  localparam logic [2:0] OP_FILL  = 3'd4;

  localparam logic [1:0] DIR_W = 2'd0;
  localparam logic [1:0] DIR_N = 2'd1;
  localparam logic [1:0] DIR_E = 2'd2;
  localparam logic [1:0] DIR_S = 2'd3;

  localparam logic [3:0] SIDE_W = 4'd8;
  localparam logic [3:0] SIDE_N = 4'd4;
  localparam logic [3:0] SIDE_E = 4'd2;
  localparam logic [3:0] SIDE_S = 4'd1;

  // masks with a single open side
  localparam logic [3:0] DEAD_OPEN_W = 4'd7;
  localparam logic [3:0] DEAD_OPEN_N = 4'd11;
  localparam logic [3:0] DEAD_OPEN_E = 4'd13;
  localparam logic [3:0] DEAD_OPEN_S = 4'd14;

  function automatic logic [3:0] side_mask(input logic [1:0] dir);
    logic [3:0] m;
    unique case (dir)
      DIR_W:   m = SIDE_W;
      DIR_N:   m = SIDE_N;
      DIR_E:   m = SIDE_E;
      default: m = SIDE_S;
    endcase
    return m;
  endfunction

endpackage

FILE: src/maze_wall_map_unit.sv
`timescale 1ns / 1ps
// maze_wall_map_unit: top level, wall mask store with opcode sequencer
// depends on mwm_pkg and mwm_ram
// check and unused opcodes read the cell; mark writes the cell, then the facing side of its
// neighbour unless that lies outside the grid; a point request outside the grid is a bad request
// clear sweeps the whole store; boundaries reads and writes back each of the width*height cells
// fill visits each cell and closes the facing side of a dead end's neighbour (one write port)
// boundaries and fill change nothing on an empty grid; a stalled
// result holds the unit; after reset the whole store (4**clog2(MAX_SIDE) cells, 4096 by default)
// is swept to zero, input stalled meanwhile; registers reset to 64 x 64, goal (0,0)

module maze_wall_map_unit
  import mwm_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o
);

  localparam int CW    = $clog2(MAX_SIDE);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int SW    = $clog2(MAX_SIDE + 1);
  localparam int UW    = (SW > CfgDataW) ? SW : CfgDataW;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_BOUND, S_FILL_RD, S_FILL_EV, S_FILL_WR,
    S_MARK1, S_MARK2, S_FREAD, S_RDATA, S_WAIT
  } state_e;

  state_e              state_q;
  logic [CfgDataW-1:0] cfg_w_q, cfg_h_q;
  logic [5:0]          goal_x_q, goal_y_q;
  in_item_t            req_q;
  logic                req_in_q;
  logic [CW-1:0]       bx_q, by_q;
  logic                bgo_q, pend_q;
  logic [AW-1:0]       paddr_q, clr_cnt_q;
  logic [3:0]          pmask_q, walls_q;
  out_item_t           res_q, out_q;
  logic                out_valid_q;

  logic [UW-1:0] uw, uh;
  logic          grid_empty, in_acc, in_inside, out_free;
  logic [AW-1:0] in_addr, req_addr, scan_addr, nb_addr;
  logic          scan_last_x, scan_last_y, scan_last, is_goal;
  logic [3:0]    bound_mask;
  logic          dead;
  logic [1:0]    open_dir;
  logic [CW-1:0] nb_sx, nb_sy, nb_x, nb_y;
  logic [1:0]    nb_dir;
  logic          nb_ok;
  logic [3:0]    nb_mask;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [3:0]    ram_wdata, ram_rdata;
  logic          fin;
  out_item_t     fin_res;

  mwm_ram #(
    .WIDTH (4),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q  <= CfgDataW'(64);
      cfg_h_q  <= CfgDataW'(64);
      goal_x_q <= '0;
      goal_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAZE_WIDTH:  cfg_w_q  <= cfg_wdata_i;
        CFG_MAZE_HEIGHT: cfg_h_q  <= cfg_wdata_i;
        CFG_GOAL_X:      goal_x_q <= cfg_wdata_i[5:0];
        default:         goal_y_q <= cfg_wdata_i[5:0];
      endcase
    end
  end

  // grid size clipped to the store
  assign uw = (UW'(cfg_w_q) > UW'(MAX_SIDE)) ? UW'(MAX_SIDE) : UW'(cfg_w_q);
  assign uh = (UW'(cfg_h_q) > UW'(MAX_SIDE)) ? UW'(MAX_SIDE) : UW'(cfg_h_q);
  assign grid_empty = (uw == '0) || (uh == '0);

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_inside  = (UW'(in_data_i.cell_x) < uw) && (UW'(in_data_i.cell_y) < uh);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign in_addr   = {CW'(in_data_i.cell_y), CW'(in_data_i.cell_x)};
  assign req_addr  = {CW'(req_q.cell_y), CW'(req_q.cell_x)};
  assign scan_addr = {by_q, bx_q};

  assign scan_last_x = (UW'(bx_q) + UW'(1)) == uw;
  assign scan_last_y = (UW'(by_q) + UW'(1)) == uh;
  assign scan_last   = scan_last_x && scan_last_y;
  assign is_goal     = (UW'(bx_q) == UW'(goal_x_q)) && (UW'(by_q) == UW'(goal_y_q));

  assign bound_mask = ((bx_q == '0) ? SIDE_W : 4'd0) | (scan_last_x ? SIDE_E : 4'd0)
                    | ((by_q == '0) ? SIDE_N : 4'd0) | (scan_last_y ? SIDE_S : 4'd0);

  // dead-end decode of the scanned cell
  always_comb begin
    dead     = 1'b1;
    open_dir = DIR_W;
    unique case (ram_rdata)
      DEAD_OPEN_W: open_dir = DIR_W;
      DEAD_OPEN_N: open_dir = DIR_N;
      DEAD_OPEN_E: open_dir = DIR_E;
      DEAD_OPEN_S: open_dir = DIR_S;
      default:     dead     = 1'b0;
    endcase
  end

  // neighbour beyond one side, shared by mark and fill
  always_comb begin
    if (state_q == S_MARK1) begin
      nb_sx  = CW'(req_q.cell_x);
      nb_sy  = CW'(req_q.cell_y);
      nb_dir = req_q.direction;
    end else begin
      nb_sx  = bx_q;
      nb_sy  = by_q;
      nb_dir = open_dir;
    end
    nb_x = nb_sx;
    nb_y = nb_sy;
    unique case (nb_dir)
      DIR_W: begin
        nb_ok = (nb_sx != '0);
        nb_x  = nb_sx - CW'(1);
      end
      DIR_N: begin
        nb_ok = (nb_sy != '0);
        nb_y  = nb_sy - CW'(1);
      end
      DIR_E: begin
        nb_ok = (UW'(nb_sx) + UW'(1)) < uw;
        nb_x  = nb_sx + CW'(1);
      end
      default: begin
        nb_ok = (UW'(nb_sy) + UW'(1)) < uh;
        nb_y  = nb_sy + CW'(1);
      end
    endcase
    nb_addr = {nb_y, nb_x};
    nb_mask = side_mask(nb_dir ^ DIR_E);
  end

  // store port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = paddr_q;
    ram_wdata = ram_rdata | pmask_q;
    ram_re    = 1'b0;
    ram_raddr = scan_addr;
    unique case (state_q)
      S_INIT, S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
      end
      S_IDLE: begin
        ram_re    = in_acc;
        ram_raddr = in_addr;
      end
      S_BOUND: begin
        ram_re = bgo_q;
        ram_we = pend_q;
      end
      S_FILL_RD: ram_re = 1'b1;
      S_FILL_EV: begin
        ram_re    = dead && !is_goal && nb_ok;
        ram_raddr = nb_addr;
      end
      S_FILL_WR, S_MARK2: ram_we = 1'b1;
      S_MARK1: begin
        ram_we    = 1'b1;
        ram_waddr = req_addr;
        ram_wdata = ram_rdata | side_mask(req_q.direction);
        ram_re    = nb_ok;
        ram_raddr = nb_addr;
      end
      S_FREAD: begin
        ram_re    = req_in_q;
        ram_raddr = req_addr;
      end
      default: ;
    endcase
  end

  // result ready this cycle
  always_comb begin
    fin                  = 1'b0;
    fin_res.wall_present = 1'b0;
    fin_res.cell_walls   = '0;
    fin_res.bad_request  = !req_in_q;
    unique case (state_q)
      S_IDLE: begin
        fin = in_acc && !in_inside && (in_data_i.opcode != OP_CLEAR)
           && (in_data_i.opcode != OP_BOUND) && (in_data_i.opcode != OP_FILL);
        fin_res.bad_request = 1'b1;
      end
      S_CLEAR: fin = (clr_cnt_q == '1);
      S_FREAD: fin = !req_in_q;
      S_RDATA: begin
        fin                  = 1'b1;
        fin_res.wall_present = (req_q.opcode == OP_CHECK)
                            && ((ram_rdata & side_mask(req_q.direction)) != '0);
        fin_res.cell_walls   = ram_rdata;
      end
      S_MARK1: begin
        fin                = !nb_ok;
        fin_res.cell_walls = ram_rdata | side_mask(req_q.direction);
      end
      S_MARK2: begin
        fin                = 1'b1;
        fin_res.cell_walls = walls_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      clr_cnt_q   <= '0;
      req_q       <= '0;
      req_in_q    <= 1'b0;
      bx_q        <= '0;
      by_q        <= '0;
      bgo_q       <= 1'b0;
      pend_q      <= 1'b0;
      paddr_q     <= '0;
      pmask_q     <= '0;
      walls_q     <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == '1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            req_q     <= in_data_i;
            req_in_q  <= in_inside;
            bx_q      <= '0;
            by_q      <= '0;
            bgo_q     <= 1'b1;
            pend_q    <= 1'b0;
            clr_cnt_q <= '0;
            unique case (in_data_i.opcode)
              OP_CLEAR: state_q <= S_CLEAR;
              OP_BOUND: state_q <= grid_empty ? S_FREAD : S_BOUND;
              OP_FILL:  state_q <= grid_empty ? S_FREAD : S_FILL_RD;
              OP_MARK:  state_q <= S_MARK1;
              default:  state_q <= S_RDATA;
            endcase
          end
        end
        S_CLEAR: clr_cnt_q <= clr_cnt_q + AW'(1);
        S_BOUND: begin
          // read one cell a cycle, write it back the next
          pend_q  <= bgo_q;
          paddr_q <= scan_addr;
          pmask_q <= bound_mask;
          if (bgo_q) begin
            bx_q <= scan_last_x ? '0 : bx_q + CW'(1);
            by_q <= scan_last_x ? by_q + CW'(1) : by_q;
            if (scan_last) begin
              bgo_q <= 1'b0;
            end
          end else begin
            state_q <= S_FREAD;
          end
        end
        S_FILL_RD: state_q <= S_FILL_EV;
        S_FILL_EV: begin
          if (dead && !is_goal && nb_ok) begin
            paddr_q <= nb_addr;
            pmask_q <= nb_mask;
            state_q <= S_FILL_WR;
          end else begin
            bx_q    <= scan_last_x ? '0 : bx_q + CW'(1);
            by_q    <= scan_last_x ? by_q + CW'(1) : by_q;
            state_q <= scan_last ? S_FREAD : S_FILL_RD;
          end
        end
        S_FILL_WR: begin
          bx_q    <= scan_last_x ? '0 : bx_q + CW'(1);
          by_q    <= scan_last_x ? by_q + CW'(1) : by_q;
          state_q <= scan_last ? S_FREAD : S_FILL_RD;
        end
        S_MARK1: begin
          walls_q <= ram_rdata | side_mask(req_q.direction);
          paddr_q <= nb_addr;
          pmask_q <= nb_mask;
          state_q <= S_MARK2;
        end
        S_FREAD: state_q <= S_RDATA;
        S_WAIT: begin
          if (out_free) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: ;
      endcase
      // result goes straight to the output register when it is free
      if (fin) begin
        if (out_free) begin
          out_q       <= fin_res;
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end else begin
          res_q   <= fin_res;
          state_q <= S_WAIT;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a write and a read in the same cycle always target different cells
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("store read and write collide on one cell");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((state_q != S_IDLE) && (state_q != S_WAIT) && (state_q != S_RDATA)
                && (state_q != S_FREAD)))
    else $error("store written outside a modifying step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> !out_valid_q)
    else $error("result presented during the clearing pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) != S_INIT) && ($past(state_q) != S_BOUND))
    else $error("result produced from a scanning step");

endmodule

FILE: src/mwm_ram.sv
`timescale 1ns / 1ps
// mwm_ram: generic simple dual-port ram, one write and one registered read
// no dependencies

module mwm_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/mwm_wall_checker.sv
`timescale 1ns / 1ps
// mwm_wall_checker: watches the request, result and register ports of the wall map
// keeps its own wall grid, predicts each result and compares field by field; uses mwm_pkg

module mwm_wall_checker
  import mwm_pkg::*;
#(
  parameter int MAX_SIDE = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_item_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_item_t           out_data_i,
  output logic                idle_o,
  output int unsigned         mismatch_count_o
);

  logic [3:0]  wall_map [MAX_SIDE*MAX_SIDE];
  logic [6:0]  width_q;
  logic [6:0]  height_q;
  logic [5:0]  goal_x_q;
  logic [5:0]  goal_y_q;
  out_item_t   walls_due [$];
  int unsigned fails = 0;

  assign mismatch_count_o = fails;

  function automatic int grid_cols();
    return (width_q > MAX_SIDE) ? MAX_SIDE : int'(width_q);
  endfunction

  function automatic int grid_rows();
    return (height_q > MAX_SIDE) ? MAX_SIDE : int'(height_q);
  endfunction

  function automatic int cell_index(input int x, input int y);
    return y * MAX_SIDE + x;
  endfunction

  function automatic logic [3:0] wall_bit(input logic [1:0] dir);
    case (dir)
      DIR_W:   return SIDE_W;
      DIR_N:   return SIDE_N;
      DIR_E:   return SIDE_E;
      default: return SIDE_S;
    endcase
  endfunction

  function automatic logic [1:0] facing(input logic [1:0] dir);
    case (dir)
      DIR_W:   return DIR_E;
      DIR_N:   return DIR_S;
      DIR_E:   return DIR_W;
      default: return DIR_N;
    endcase
  endfunction

  function automatic void set_wall(input int x, input int y, input logic [3:0] m);
    wall_map[cell_index(x, y)] = wall_map[cell_index(x, y)] | m;
  endfunction

  // closes the side of the neighbour that faces (x,y) across dir, if it lies in the grid
  function automatic void close_facing(input int x, input int y, input logic [1:0] dir);
    int nx;
    int ny;
    nx = x;
    ny = y;
    case (dir)
      DIR_W:   nx = x - 1;
      DIR_N:   ny = y - 1;
      DIR_E:   nx = x + 1;
      default: ny = y + 1;
    endcase
    if (nx < 0 || ny < 0 || nx >= grid_cols() || ny >= grid_rows()) return;
    set_wall(nx, ny, wall_bit(facing(dir)));
  endfunction

  function automatic void mark_outline(input int cols, input int rows);
    if (cols == 0 || rows == 0) return;
    for (int i = 0; i < rows; i++) begin
      set_wall(0, i, SIDE_W);
      set_wall(cols - 1, i, SIDE_E);
    end
    for (int i = 0; i < cols; i++) begin
      set_wall(i, 0, SIDE_N);
      set_wall(i, rows - 1, SIDE_S);
    end
  endfunction

  // single raster pass, later cells see walls closed earlier in the same pass
  function automatic void fill_dead_ends(input int cols, input int rows);
    for (int y = 0; y < rows; y++) begin
      for (int x = 0; x < cols; x++) begin
        if (x == goal_x_q && y == goal_y_q) continue;
        case (wall_map[cell_index(x, y)])
          DEAD_OPEN_W: close_facing(x, y, DIR_W);
          DEAD_OPEN_N: close_facing(x, y, DIR_N);
          DEAD_OPEN_E: close_facing(x, y, DIR_E);
          DEAD_OPEN_S: close_facing(x, y, DIR_S);
          default: ;
        endcase
      end
    end
  endfunction

  function automatic out_item_t apply_request(input in_item_t req);
    out_item_t res;
    int        cols;
    int        rows;
    int        x;
    int        y;
    logic      hit;
    cols = grid_cols();
    rows = grid_rows();
    x    = req.cell_x;
    y    = req.cell_y;
    hit  = (x < cols) && (y < rows);
    res  = '0;
    case (req.opcode)
      OP_CLEAR: foreach (wall_map[i]) wall_map[i] = '0;
      OP_BOUND: mark_outline(cols, rows);
      OP_MARK: begin
        if (hit) begin
          set_wall(x, y, wall_bit(req.direction));
          close_facing(x, y, req.direction);
        end
      end
      OP_CHECK: begin
        if (hit) res.wall_present = |(wall_map[cell_index(x, y)] & wall_bit(req.direction));
      end
      OP_FILL: fill_dead_ends(cols, rows);
      default: ;
    endcase
    if (hit) res.cell_walls = wall_map[cell_index(x, y)];
    else res.bad_request = 1'b1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      foreach (wall_map[i]) wall_map[i] = '0;
      width_q  = 7'(MAX_SIDE);
      height_q = 7'(MAX_SIDE);
      goal_x_q = '0;
      goal_y_q = '0;
      walls_due.delete();
      idle_o <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAZE_WIDTH:  width_q  = cfg_wdata_i;
          CFG_MAZE_HEIGHT: height_q = cfg_wdata_i;
          CFG_GOAL_X:      goal_x_q = cfg_wdata_i[5:0];
          CFG_GOAL_Y:      goal_y_q = cfg_wdata_i[5:0];
          default: ;
        endcase
      end
      // results first: a result never belongs to a transaction accepted at the same edge
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        if (walls_due.size() == 0) begin
          $error("result transaction with nothing expected: %p", out_data_i);
          fails++;
        end else begin
          want = walls_due.pop_front();
          if (out_data_i.wall_present !== want.wall_present) begin
            $error("wall_present: expected %0d, got %0d", want.wall_present,
                   out_data_i.wall_present);
            fails++;
          end
          if (out_data_i.cell_walls !== want.cell_walls) begin
            $error("cell_walls: expected %0d, got %0d", want.cell_walls,
                   out_data_i.cell_walls);
            fails++;
          end
          if (out_data_i.bad_request !== want.bad_request) begin
            $error("bad_request: expected %0d, got %0d", want.bad_request,
                   out_data_i.bad_request);
            fails++;
          end
        end
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) walls_due.push_back(apply_request(in_data_i));
      idle_o <= (walls_due.size() == 0);
    end
  end

endmodule

FILE: tb/tb_maze_wall_map_unit.sv
`timescale 1ns / 1ps
// tb_maze_wall_map_unit: stimulus and verdict for the maze wall map unit
// drives directed and random requests with random gaps and stalls; uses mwm_pkg, mwm_wall_checker

module tb_maze_wall_map_unit
  import mwm_pkg::*;
();

  localparam int MAX_SIDE     = 64;
  localparam int RANDOM_ITEMS = 620;
  localparam int OpCount      = 8;
  localparam int DrainCycles  = 50;

  logic          clk         = 1'b0;
  logic          rst_n       = 1'b0;
  logic          cfg_we      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic          in_valid    = 1'b0;
  in_item_t      in_data     = '0;
  logic          out_stall   = 1'b0;
  logic          in_stall;
  logic          out_valid;
  out_item_t     out_data;
  logic          map_idle;
  int unsigned   mismatches;

  int cur_cols;
  int cur_rows;
  bit quiet_phase = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  maze_wall_map_unit #(
    .MAX_SIDE(MAX_SIDE)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  mwm_wall_checker #(
    .MAX_SIDE(MAX_SIDE)
  ) wall_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .idle_o          (map_idle),
    .mismatch_count_o(mismatches)
  );

  function automatic int request_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_req(input logic [2:0] op, input int x, input int y,
                          input logic [1:0] dir);
    in_item_t req;
    int       gap;
    req.opcode    = op;
    req.cell_x    = x[5:0];
    req.cell_y    = y[5:0];
    req.direction = dir;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    gap = request_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // every result back before anything else happens
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (map_idle !== 1'b1);
  endtask

  task automatic set_grid(input int w, input int h, input int gx, input int gy);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MAZE_WIDTH;
    cfg_wdata <= 7'(w);
    @(posedge clk);
    cfg_idx   <= CFG_MAZE_HEIGHT;
    cfg_wdata <= 7'(h);
    @(posedge clk);
    cfg_idx   <= CFG_GOAL_X;
    cfg_wdata <= 7'(gx);
    @(posedge clk);
    cfg_idx   <= CFG_GOAL_Y;
    cfg_wdata <= 7'(gy);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_cols = (w > MAX_SIDE) ? MAX_SIDE : w;
    cur_rows = (h > MAX_SIDE) ? MAX_SIDE : h;
  endtask

  // mostly in-grid marks and checks on a bounded maze, with the odd stray transaction
  task automatic run_maze(input int n);
    int         r;
    int         x;
    int         y;
    logic [2:0] op;
    if ($urandom_range(0, 2) == 0) send_req(OP_CLEAR, $urandom_range(0, 63), 0, DIR_W);
    send_req(OP_BOUND, 0, 0, DIR_N);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 45) op = OP_MARK;
      else if (r < 75) op = OP_CHECK;
      else if (r < 85) op = OP_FILL;
      else if (r < 90) op = OP_BOUND;
      else if (r < 92) op = OP_CLEAR;
      else op = 3'($urandom_range(int'(OP_FILL) + 1, OpCount - 1));
      if ($urandom_range(0, 9) == 0) begin
        x = $urandom_range(0, 63);
        y = $urandom_range(0, 63);
      end else begin
        x = $urandom_range(0, (cur_cols > 0) ? cur_cols - 1 : 0);
        y = $urandom_range(0, (cur_rows > 0) ? cur_rows - 1 : 0);
      end
      send_req(op, x, y, 2'($urandom_range(0, 3)));
    end
  endtask

  task automatic drive_phase(input int w, input int h, input int gx, input int gy,
                             input int n);
    set_grid(w, h, gx, gy);
    run_maze(n);
  endtask

  initial begin : out_stall_drive
    int run_len;
    int hold_len;
    @(posedge rst_n);
    forever begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 6);
      repeat (run_len) @(posedge clk);
      out_stall <= 1'b1;
      hold_len = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
      repeat (hold_len) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  initial begin : stimulus
    int sent;
    int pick;
    int w;
    int h;
    int gx;
    int gy;
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // small maze, goal at (4,3)
    set_grid(6, 5, 4, 3);
    send_req(OP_CLEAR, 0, 0, DIR_W);
    send_req(OP_BOUND, 63, 63, DIR_S);
    send_req(OP_CHECK, 0, 0, DIR_W);
    send_req(OP_CHECK, 5, 4, DIR_E);
    send_req(OP_CHECK, 5, 4, DIR_S);
    send_req(OP_MARK, 3, 2, DIR_N);
    send_req(OP_CHECK, 3, 1, DIR_S);
    send_req(OP_MARK, 6, 0, DIR_W);
    send_req(OP_CHECK, 0, 5, DIR_N);
    // dead end at (1,1) opening south
    send_req(OP_MARK, 1, 1, DIR_W);
    send_req(OP_MARK, 1, 1, DIR_N);
    send_req(OP_MARK, 1, 1, DIR_E);
    // dead end on the goal cell, must stay open towards (5,3)
    send_req(OP_MARK, 4, 3, DIR_W);
    send_req(OP_MARK, 4, 3, DIR_N);
    send_req(OP_MARK, 4, 3, DIR_S);
    send_req(OP_FILL, 1, 2, DIR_N);
    send_req(OP_CHECK, 1, 2, DIR_N);
    send_req(OP_CHECK, 5, 3, DIR_W);
    for (int k = int'(OP_FILL) + 1; k < OpCount; k++) send_req(3'(k), 1, 1, DIR_S);

    // extreme grid settings
    quiet_phase = 1'b1;
    drive_phase(1, 1, 63, 63, 20);
    quiet_phase = 1'b0;
    drive_phase(0, 127, 0, 0, 15);
    drive_phase(127, 127, 63, 63, 15);
    drive_phase(64, 1, 63, 0, 25);
    drive_phase(1, 64, 0, 63, 25);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        w = $urandom_range(40, 127);
        h = $urandom_range(40, 127);
        n = 12;
      end else if (pick == 1) begin
        w = $urandom_range(0, 2);
        h = $urandom_range(0, 2);
        n = 25;
      end else begin
        w = $urandom_range(2, 12);
        h = $urandom_range(2, 12);
        n = $urandom_range(40, 90);
      end
      if ($urandom_range(0, 4) == 0) begin
        gx = $urandom_range(0, 63);
        gy = $urandom_range(0, 63);
      end else begin
        gx = $urandom_range(0, (w > 1) ? ((w > MAX_SIDE) ? MAX_SIDE : w) - 1 : 0);
        gy = $urandom_range(0, (h > 1) ? ((h > MAX_SIDE) ? MAX_SIDE : h) - 1 : 0);
      end
      quiet_phase = ($urandom_range(0, 4) == 0);
      drive_phase(w, h, gx, gy, n);
      sent += n;
    end

    settle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("maze_wall_map_unit verification clean");
    end else begin
      $display("maze_wall_map_unit verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("maze_wall_map_unit verification failed");
    $finish;
  end

endmodule
